// File: rtl/iklpt_pkg.sv
// Package for the IPv4-keyed linear probing table.
// Holds the beat types, status codes, hash constants and the hash step function.
// No dependencies.
package iklpt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int SLOT_W              = 10;
  localparam int OCC_W               = 10;
  localparam int MIX_STEPS           = 6;

  localparam logic [31:0] MIX_K0 = 32'h7ed55d16;
  localparam logic [31:0] MIX_K1 = 32'hc761c23c;
  localparam logic [31:0] MIX_K2 = 32'h165667b1;
  localparam logic [31:0] MIX_K3 = 32'hd3a2646c;
  localparam logic [31:0] MIX_K4 = 32'hfd7046c5;
  localparam logic [31:0] MIX_K5 = 32'hb55a4f09;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_FOUND   = 3'd0,
    ST_MISS    = 3'd1,
    ST_NEW     = 3'd2,
    ST_UPDATED = 3'd3,
    ST_FULL    = 3'd4,
    ST_ZEROKEY = 3'd5
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] user_ref;
    logic [31:0] pass_ref;
  } in_beat_t;

  typedef struct packed {
    status_t           status;
    logic [31:0]       user_out;
    logic [31:0]       pass_out;
    logic [SLOT_W-1:0] slot;
    logic [OCC_W-1:0]  occupancy;
  } out_beat_t;

  function automatic logic [31:0] mix_step(input logic [31:0] v, input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0:    r = (v + MIX_K0) + (v << 12);
      3'd1:    r = (v ^ MIX_K1) ^ (v >> 19);
      3'd2:    r = (v + MIX_K2) + (v << 5);
      3'd3:    r = (v + MIX_K3) ^ (v << 9);
      3'd4:    r = (v + MIX_K4) + (v << 3);
      3'd5:    r = (v ^ MIX_K5) ^ (v >> 16);
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/iklpt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module iklpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/iklpt_home.sv
// Home slot unit: runs the six-step integer hash one step per cycle, then, unless
// the depth is a power of two, reduces it modulo the depth by a reciprocal multiply,
// a multiply-subtract and one correction step. Depends on iklpt_pkg.
module iklpt_home #(
  parameter int TABLE_DEPTH = iklpt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [31:0]                    key,
  output logic                           done,
  output logic [$clog2(TABLE_DEPTH)-1:0] home
);

  localparam int          AW      = $clog2(TABLE_DEPTH);
  localparam int          RW      = AW + 1;
  localparam int          SH      = 31 + AW;
  localparam bit          IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam logic [63:0] RECIP   = (64'd1 << SH) / 64'(TABLE_DEPTH);
  localparam logic [31:0] RECIP_M = RECIP[31:0];

  typedef enum logic [2:0] {
    H_IDLE,
    H_MIX,
    H_MUL,
    H_SUB,
    H_FIX
  } hstate_t;

  hstate_t       state_r, state_nxt;
  logic [31:0]   v_r, v_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] home_r, home_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   v_step;
  logic [31:0]   quo;
  logic [31:0]   quo_d;
  logic [31:0]   rem_full;
  logic [RW-1:0] rem_sub;

  assign v_step   = iklpt_pkg::mix_step(v_r, step_r);
  assign quo      = 32'(prod_r >> SH);
  assign quo_d    = quo * 32'(TABLE_DEPTH);
  assign rem_full = v_r - quo_d;
  assign rem_sub  = rem_r - RW'(TABLE_DEPTH);

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    home_nxt  = home_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      H_IDLE: begin
        if (go) begin
          v_nxt     = key;
          step_nxt  = 3'd0;
          state_nxt = H_MIX;
        end
      end
      H_MIX: begin
        v_nxt    = v_step;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(iklpt_pkg::MIX_STEPS - 1)) begin
          if (IS_POW2) begin
            home_nxt  = v_step[AW-1:0];
            done_nxt  = 1'b1;
            state_nxt = H_IDLE;
          end else begin
            state_nxt = H_MUL;
          end
        end
      end
      H_MUL: begin
        prod_nxt  = 64'(v_r) * 64'(RECIP_M);
        state_nxt = H_SUB;
      end
      H_SUB: begin
        rem_nxt   = rem_full[RW-1:0];
        state_nxt = H_FIX;
      end
      H_FIX: begin
        if (rem_r >= RW'(TABLE_DEPTH)) begin
          home_nxt = rem_sub[AW-1:0];
        end else begin
          home_nxt = rem_r[AW-1:0];
        end
        done_nxt  = 1'b1;
        state_nxt = H_IDLE;
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    v_r    <= v_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    home_r <= home_nxt;
  end

  assign done = done_r;
  assign home = home_r;

endmodule

// File: rtl/ip_keyed_linear_probe_table.sv
// Top level of the IPv4-keyed open-addressing table with linear probing.
// Depends on iklpt_pkg, iklpt_ram and iklpt_home.
//
//   Channel   Handshake            Payload
//   input     start / busy         in_data  (iklpt_pkg::in_beat_t)
//   result    out_valid strobe     out_data (iklpt_pkg::out_beat_t)
//
// A beat is accepted when start is high and busy is low. A zero key is answered
// in the cycle after it is accepted. Any other key passes through the hash and
// its handoff, the modulo when the depth is not a power of two, a read and a check
// state for each slot probed on the key RAM read port, then the result register.
// After reset the block clears the key RAM one slot per cycle with busy high.
// Each result shows for one cycle; the receiver cannot stall it.
module ip_keyed_linear_probe_table #(
  parameter int TABLE_DEPTH = iklpt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  iklpt_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  output iklpt_pkg::out_beat_t out_data
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int HALF = TABLE_DEPTH / 2;
  localparam int CW   = $clog2(HALF + 1);
  localparam int NW   = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_RD,
    S_CHK
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW-1:0]        p_r, p_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  iklpt_pkg::in_beat_t  req_r, req_nxt;
  logic                 out_valid_r, out_valid_nxt;
  iklpt_pkg::out_beat_t out_data_r, out_data_nxt;

  logic          hash_go;
  logic          hash_done;
  logic [AW-1:0] home;

  logic          key_we;
  logic [AW-1:0] key_waddr;
  logic [31:0]   key_wdata;
  logic [31:0]   key_rdata;
  logic          val_we;
  logic [63:0]   val_rdata;

  logic          slot_empty;
  logic          slot_hit;
  logic [AW-1:0] p_wrap;
  logic [NW-1:0] n_inc;
  logic          exhaust;
  logic [AW-1:0] fin_pos;
  logic [31:0]   fin_pos_ext;
  logic [31:0]   cnt_ext;

  iklpt_home #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_home (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (hash_go),
    .key  (in_data.key),
    .done (hash_done),
    .home (home)
  );

  iklpt_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_waddr),
    .wdata(key_wdata),
    .raddr(p_r),
    .rdata(key_rdata)
  );

  iklpt_ram #(
    .WIDTH(64),
    .DEPTH(TABLE_DEPTH)
  ) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(p_r),
    .wdata({req_r.user_ref, req_r.pass_ref}),
    .raddr(p_r),
    .rdata(val_rdata)
  );

  assign slot_empty  = (key_rdata == 32'd0);
  assign slot_hit    = (key_rdata == req_r.key);
  assign p_wrap      = (p_r == AW'(TABLE_DEPTH - 1)) ? '0 : p_r + AW'(1);
  assign n_inc       = n_r + NW'(1);
  assign exhaust     = !slot_empty && !slot_hit && (n_inc == NW'(TABLE_DEPTH));
  assign fin_pos     = exhaust ? p_wrap : p_r;
  assign fin_pos_ext = 32'(fin_pos);
  assign cnt_ext     = 32'(cnt_nxt);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    hash_go       = 1'b0;
    key_we        = 1'b0;
    key_waddr     = p_r;
    key_wdata     = req_r.key;
    val_we        = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_r;
        key_wdata = 32'd0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          if (in_data.key == 32'd0) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.status    = iklpt_pkg::ST_ZEROKEY;
            out_data_nxt.user_out  = 32'd0;
            out_data_nxt.pass_out  = 32'd0;
            out_data_nxt.slot      = '0;
            out_data_nxt.occupancy = cnt_ext[iklpt_pkg::OCC_W-1:0];
          end else begin
            hash_go   = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          p_nxt     = home;
          n_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (slot_empty || slot_hit || exhaust) begin
          out_data_nxt.user_out = 32'd0;
          out_data_nxt.pass_out = 32'd0;
          if (req_r.op == iklpt_pkg::OP_LOOKUP) begin
            if (slot_hit) begin
              out_data_nxt.status   = iklpt_pkg::ST_FOUND;
              out_data_nxt.user_out = val_rdata[63:32];
              out_data_nxt.pass_out = val_rdata[31:0];
            end else begin
              out_data_nxt.status = iklpt_pkg::ST_MISS;
            end
          end else if (slot_hit) begin
            val_we              = 1'b1;
            out_data_nxt.status = iklpt_pkg::ST_UPDATED;
          end else if ((cnt_r >= CW'(HALF)) || !slot_empty) begin
            out_data_nxt.status = iklpt_pkg::ST_FULL;
          end else begin
            key_we              = 1'b1;
            val_we              = 1'b1;
            cnt_nxt             = cnt_r + CW'(1);
            out_data_nxt.status = iklpt_pkg::ST_NEW;
          end
          out_data_nxt.slot      = fin_pos_ext[iklpt_pkg::SLOT_W-1:0];
          out_data_nxt.occupancy = cnt_ext[iklpt_pkg::OCC_W-1:0];
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end else begin
          p_nxt     = p_wrap;
          n_nxt     = n_inc;
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/ip_keyed_linear_probe_table_tb.sv
// Testbench for ip_keyed_linear_probe_table: directed and random insert/lookup beats,
// each checked against an in-bench model of the hashed table with linear probing.
// Depends on iklpt_pkg and the block's RTL only.
module ip_keyed_linear_probe_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iklpt_pkg::*;

  localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS  = 1780;

  class table_scoreboard;
    logic [31:0] key_mem[DEPTH];
    logic [31:0] user_mem[DEPTH];
    logic [31:0] pass_mem[DEPTH];
    int unsigned occupied;
    out_beat_t   pending_replies[$];
    int          errors;

    function new();
      foreach (key_mem[i]) begin
        key_mem[i]  = '0;
        user_mem[i] = '0;
        pass_mem[i] = '0;
      end
      occupied = 0;
      errors   = 0;
    endfunction

    static function logic [31:0] scramble(logic [31:0] v);
      logic [31:0] h;
      h = v;
      h = (h + MIX_K0) + (h << 12);
      h = (h ^ MIX_K1) ^ (h >> 19);
      h = (h + MIX_K2) + (h << 5);
      h = (h + MIX_K3) ^ (h << 9);
      h = (h + MIX_K4) + (h << 3);
      h = (h ^ MIX_K5) ^ (h >> 16);
      return h;
    endfunction

    static function int unsigned home_of(logic [31:0] k);
      return scramble(k) % DEPTH;
    endfunction

    function void predict_probe(in_beat_t b);
      out_beat_t   e;
      int unsigned pos;
      bit          hit;
      e = '0;
      pos = 0;
      hit = 1'b0;
      if (b.key == '0) begin
        e.status = ST_ZEROKEY;
      end else begin
        pos = home_of(b.key);
        for (int n = 0; n < DEPTH; n++) begin
          if (key_mem[pos] == '0) break;
          if (key_mem[pos] == b.key) begin
            hit = 1'b1;
            break;
          end
          pos = (pos + 1) % DEPTH;
        end
        if (b.op == OP_LOOKUP) begin
          if (hit) begin
            e.status   = ST_FOUND;
            e.user_out = user_mem[pos];
            e.pass_out = pass_mem[pos];
          end else begin
            e.status = ST_MISS;
          end
        end else if (hit) begin
          user_mem[pos] = b.user_ref;
          pass_mem[pos] = b.pass_ref;
          e.status      = ST_UPDATED;
        end else if (occupied >= DEPTH / 2 || key_mem[pos] != '0) begin
          e.status = ST_FULL;
        end else begin
          key_mem[pos]  = b.key;
          user_mem[pos] = b.user_ref;
          pass_mem[pos] = b.pass_ref;
          occupied++;
          e.status = ST_NEW;
        end
      end
      e.slot      = pos[SLOT_W-1:0];
      e.occupancy = occupied[OCC_W-1:0];
      pending_replies.push_back(e);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_reply(out_beat_t got);
      out_beat_t e;
      if (pending_replies.size() == 0) begin
        report($sformatf("result beat with nothing outstanding, status %0d", got.status));
      end else begin
        e = pending_replies.pop_front();
        if (got.status != e.status)
          report($sformatf("status %0d, expected %0d", got.status, e.status));
        if (got.user_out != e.user_out)
          report($sformatf("user_out %h, expected %h", got.user_out, e.user_out));
        if (got.pass_out != e.pass_out)
          report($sformatf("pass_out %h, expected %h", got.pass_out, e.pass_out));
        if (got.slot != e.slot)
          report($sformatf("slot %0d, expected %0d", got.slot, e.slot));
        if (got.occupancy != e.occupancy)
          report($sformatf("occupancy %0d, expected %0d", got.occupancy, e.occupancy));
      end
    endtask
  endclass

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_beat_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_beat_t out_data;

  table_scoreboard sb = new();
  logic [31:0]     key_pool[$];
  bit              quiet = 1'b0;
  int              stall_cycles = 0;

  ip_keyed_linear_probe_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_reply(out_data);
      if (start && !busy) sb.predict_probe(in_data);
      if ((start && !busy) || out_valid) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("ip_keyed_linear_probe_table verification failed");
          $finish;
        end
      end
    end
  end

  task automatic send_item(op_t op, logic [31:0] k, logic [31:0] u, logic [31:0] p);
    in_beat_t b;
    bit       taken;
    b.op       = op;
    b.key      = k;
    b.user_ref = u;
    b.pass_ref = p;
    taken      = 1'b0;
    in_data <= b;
    while (!taken) begin
      start <= (quiet || $urandom_range(99) >= 34);
      @(posedge clk);
      taken = start && !busy;
    end
    if (op == OP_INSERT && k != '0) key_pool.push_back(k);
  endtask

  function automatic logic [31:0] key_with_home(int unsigned home, logic [31:0] avoid);
    logic [31:0] k;
    do begin
      k = $urandom;
    end while (k == '0 || k == avoid || table_scoreboard::home_of(k) != home);
    return k;
  endfunction

  function automatic logic [31:0] pick_handle();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_pool_key();
    if (key_pool.size() == 0) return $urandom_range(32'hffff_ffff, 1);
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  task automatic random_item();
    int unsigned r;
    logic [31:0] k;
    r = $urandom_range(99);
    if (r < 3) begin
      send_item(op_t'($urandom_range(1)), '0, pick_handle(), pick_handle());
    end else if (r < 43) begin
      if ($urandom_range(4) == 0) k = $urandom_range(64, 1);
      else k = $urandom;
      send_item(OP_INSERT, k, pick_handle(), pick_handle());
    end else if (r < 55) begin
      send_item(OP_INSERT, pick_pool_key(), pick_handle(), pick_handle());
    end else if (r < 85) begin
      send_item(OP_LOOKUP, pick_pool_key(), pick_handle(), pick_handle());
    end else begin
      send_item(OP_LOOKUP, $urandom, pick_handle(), pick_handle());
    end
  endtask

  initial begin
    logic [31:0] wrap_a, wrap_b, near_a, near_b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wrap_a = key_with_home(DEPTH - 1, '0);
    wrap_b = key_with_home(DEPTH - 1, wrap_a);
    near_a = key_with_home(table_scoreboard::home_of(32'd1), 32'd1);
    near_b = key_with_home(table_scoreboard::home_of(32'd1), near_a);

    send_item(OP_LOOKUP, '0, '0, '0);
    send_item(OP_INSERT, '0, '1, '1);
    send_item(OP_LOOKUP, 32'hffff_ffff, '1, '1);
    send_item(OP_INSERT, 32'hffff_ffff, '0, '1);
    send_item(OP_INSERT, 32'd1, '1, '0);
    send_item(OP_LOOKUP, 32'hffff_ffff, '0, '0);
    send_item(OP_LOOKUP, 32'd1, '0, '0);
    send_item(OP_INSERT, 32'd1, 32'h5555_aaaa, 32'haaaa_5555);
    send_item(OP_LOOKUP, 32'd1, '0, '0);
    send_item(OP_INSERT, wrap_a, 32'h0000_0001, 32'h8000_0000);
    send_item(OP_INSERT, wrap_b, 32'h8000_0000, 32'h0000_0001);
    send_item(OP_LOOKUP, wrap_b, '0, '0);
    send_item(OP_LOOKUP, wrap_a, '0, '0);
    send_item(OP_INSERT, near_a, 32'h1234_5678, 32'h8765_4321);
    send_item(OP_LOOKUP, near_a, '0, '0);
    send_item(OP_LOOKUP, near_b, '0, '0);
    send_item(OP_INSERT, 32'h8000_0000, '1, '1);
    send_item(OP_LOOKUP, 32'h8000_0000, '0, '0);
    send_item(OP_INSERT, wrap_b, '1, '0);
    send_item(OP_LOOKUP, wrap_b, '0, '0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i >= 700 && i < 1000);
      random_item();
    end
    start <= 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ip_keyed_linear_probe_table verification clean");
    end else begin
      $display("ip_keyed_linear_probe_table verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/iklpt_pkg.sv
rtl/iklpt_ram.sv
rtl/iklpt_home.sv
rtl/ip_keyed_linear_probe_table.sv
tb/ip_keyed_linear_probe_table_tb.sv
